FILE: design/cee_pkg.sv
// Shared types and constants of the exception entry unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
package cee_pkg;

	localparam logic [1:0] OP_RANGE_WRITE = 2'd0;
	localparam logic [1:0] OP_REFILL      = 2'd1;
	localparam logic [1:0] OP_GENERAL     = 2'd2;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_FETCH = 2'd2;

	localparam logic [4:0] EXC_TLB_LOAD  = 5'd2;
	localparam logic [4:0] EXC_TLB_STORE = 5'd3;

	localparam logic [31:0] VEC_GENERAL = 32'h8000_0180;
	localparam logic [31:0] VEC_REFILL  = 32'h8000_0000;
	localparam logic [31:0] CTX_KEEP    = 32'hFF80_000F;
	localparam logic [31:0] CTX_VPN     = 32'h007F_FFF0;
	localparam logic [31:0] HI_MASK     = 32'hFFFF_E000;
	localparam logic [31:0] BD_CLEAR    = 32'h7FFF_FFFF;
	localparam logic [1:0]  KSEG0_TOP   = 2'b10;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] address;
		logic [31:0] pc;
		logic [1:0]  branch_delay;
		logic [1:0]  access_kind;
		logic        exl_in;
		logic [31:0] cause_in;
		logic [5:0]  range_slot;
		logic [31:0] range_start;
		logic [31:0] range_end;
	} item_t;

	typedef struct packed {
		logic [31:0] new_pc;
		logic [31:0] epc;
		logic        epc_written;
		logic [31:0] cause;
		logic [31:0] bad_vaddr;
		logic [31:0] context_res;
		logic [31:0] entry_hi;
		logic        tlb_regs_written;
		logic        exl_out;
		logic        cancel_branch;
	} result_t;

	typedef struct packed {
		logic item_load;
		logic hit_clear;
		logic mem_write;
		logic rd_en;
		logic cmp_en;
		logic res_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic res_busy;
	} dp_status_t;

endpackage

FILE: design/cee_if.sv
// Valid/ready channel interfaces of the exception entry unit.
// Depends on cee_pkg for the item and result word types.
interface cee_item_if import cee_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cee_result_if import cee_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cee_cfg_if ();
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/cee_ctrl.sv
// Controller of the exception entry unit: sequences accept, range write, range scan and result load.
// Depends on cee_pkg for the command and status structs.
module cee_ctrl import cee_pkg::*; #(
	parameter int ENTRY_COUNT = 32,
	parameter int RW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  dp_status_t    status,
	output ctrl_cmd_t     cmd,
	output logic [RW-1:0] rd_row
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	localparam logic [RW-1:0] LAST_ROW = RW'(ENTRY_COUNT - 1);

	logic [2:0]    state_q, state_d;
	logic [RW-1:0] row_q, row_d;
	logic          cmp_q, cmp_d;

	assign item_ready = (state_q == S_IDLE);
	assign rd_row     = row_q;

	always_comb begin
		state_d = state_q;
		row_d   = row_q;
		cmp_d   = 1'b0;
		cmd     = '0;
		cmd.cmp_en = cmp_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.hit_clear = 1'b1;
				row_d         = '0;
				if (status.need_scan) begin
					state_d = S_SCAN;
				end else begin
					cmd.mem_write = 1'b1;
					state_d       = S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				cmp_d     = 1'b1;
				if (row_q == LAST_ROW) begin
					state_d = S_DRAIN;
				end else begin
					row_d = row_q + 1'b1;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!status.res_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			cmp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			cmp_q   <= cmp_d;
		end
	end

endmodule

FILE: design/cee_dp.sv
// Datapath of the exception entry unit: item register, range memory, range compare,
// result logic and output register. Depends on cee_pkg.
module cee_dp import cee_pkg::*; #(
	parameter int ENTRY_COUNT = 32,
	parameter int RW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  item_t         item_data,
	input  logic          cfg_valid,
	input  logic [31:0]   cfg_data,
	input  ctrl_cmd_t     cmd,
	input  logic [RW-1:0] rd_row,
	output dp_status_t    status,
	output logic          res_valid,
	input  logic          res_ready,
	output result_t       res_data
);

	localparam int SlotCount = 2 * ENTRY_COUNT;

	item_t       item_q;
	logic [31:0] ctx_q;
	logic        hit_q;
	result_t     res_q;
	logic        res_vld_q;

	// each row holds the even and odd range of one entry as {start, end}
	logic [1:0][63:0]                range_mem [ENTRY_COUNT];
	logic [ENTRY_COUNT-1:0][1:0]     row_vld_q;
	logic [1:0][63:0]                rd_data_s1;
	logic [1:0]                      rd_vld_s1;

	logic [6:0]    slot_ext;
	logic [RW-1:0] wr_row;
	logic          wr_ok;
	logic [1:0]    half_hit;
	logic          in_delay;
	logic          kseg;
	logic [31:0]   epc_base;
	logic [31:0]   epc_dec;
	result_t       res_d;

	assign slot_ext = 7'(item_q.range_slot);
	assign wr_row   = RW'(slot_ext >> 1);
	assign wr_ok    = cmd.mem_write && (item_q.operation == OP_RANGE_WRITE)
		&& (32'(slot_ext) < 32'(SlotCount));

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= item_data;
		end
		if (wr_ok) begin
			range_mem[wr_row][item_q.range_slot[0]] <= {item_q.range_start, item_q.range_end};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= range_mem[rd_row];
			rd_vld_s1  <= row_vld_q[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			ctx_q     <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (wr_ok) begin
				row_vld_q[wr_row][item_q.range_slot[0]] <= 1'b1;
			end
			if (cfg_valid) begin
				ctx_q <= cfg_data;
			end
			if (cmd.hit_clear) begin
				hit_q <= 1'b0;
			end else if (cmd.cmp_en) begin
				hit_q <= hit_q | (|half_hit);
			end
		end
	end

	// a slot never written compares as start 0, end 0
	always_comb begin
		for (int h = 0; h < 2; h++) begin
			logic [31:0] lo, hi;
			lo = rd_vld_s1[h] ? rd_data_s1[h][63:32] : '0;
			hi = rd_vld_s1[h] ? rd_data_s1[h][31:0] : '0;
			half_hit[h] = (item_q.address >= lo) && (item_q.address <= hi);
		end
	end

	assign status.need_scan = (item_q.operation == OP_REFILL) && !item_q.exl_in;
	assign status.res_busy  = res_vld_q && !res_ready;

	assign in_delay = item_q.branch_delay[0];
	assign kseg     = (item_q.address[31:30] == KSEG0_TOP);
	assign epc_base = (item_q.access_kind == KIND_FETCH) ? item_q.address : item_q.pc;
	assign epc_dec  = {28'd0, in_delay && (item_q.access_kind != KIND_FETCH),
		in_delay != (item_q.access_kind != KIND_FETCH), 2'b00};

	always_comb begin
		res_d         = '0;
		res_d.exl_out = item_q.exl_in;
		case (item_q.operation)
			OP_REFILL: begin
				res_d.cause = {in_delay, 24'd0,
					(item_q.access_kind == KIND_STORE) ? EXC_TLB_STORE : EXC_TLB_LOAD, 2'b00};
				res_d.bad_vaddr        = item_q.address;
				res_d.context_res      = (ctx_q & CTX_KEEP) | ((item_q.address >> 9) & CTX_VPN);
				res_d.entry_hi         = item_q.address & HI_MASK;
				res_d.tlb_regs_written = 1'b1;
				res_d.exl_out          = 1'b1;
				res_d.cancel_branch    = (item_q.branch_delay != 2'd0);
				if (item_q.exl_in) begin
					res_d.new_pc = VEC_GENERAL;
				end else begin
					res_d.epc         = epc_base - epc_dec;
					res_d.epc_written = 1'b1;
					res_d.new_pc      = (kseg || hit_q) ? VEC_GENERAL : VEC_REFILL;
				end
			end
			OP_GENERAL: begin
				res_d.cause         = in_delay ? {1'b1, item_q.cause_in[30:0]}
					: (item_q.cause_in & BD_CLEAR);
				res_d.new_pc        = VEC_GENERAL;
				res_d.exl_out       = 1'b1;
				res_d.cancel_branch = (item_q.branch_delay != 2'd0);
				if (!item_q.exl_in) begin
					res_d.epc         = item_q.pc - {29'd0, in_delay, 2'b00};
					res_d.epc_written = 1'b1;
				end
			end
			default: begin
				res_d.exl_out = item_q.exl_in;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_vld_q <= 1'b1;
		end else if (res_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	assign res_valid = res_vld_q;
	assign res_data  = res_q;

endmodule

FILE: design/cpu_exception_entry.sv
// Top level of the exception entry unit: joins controller and datapath to the channels.
// Depends on cee_pkg, cee_if, cee_ctrl and cee_dp.
//
//   channel  dir  word
//   item     in   item_t: range write, refill or general exception
//   result   out  result_t: one word per item
//   cfg      in   32-bit Context register write, always ready
//
// Range write, general exception and refill with EXL set pass from accept to result without a scan.
// Refill with EXL clear scans the range memory one entry
// (even and odd range) per cycle through its single read port.
// Reset clears the range valid bits and Context at once; no clearing pass.
// A result waits in the output register while the next item is accepted and processed;
// that item's result is loaded only once the register is free, and no later item is accepted before.
module cpu_exception_entry import cee_pkg::*; #(
	parameter int ENTRY_COUNT = 32
) (
	input logic         clk,
	input logic         arst_n,
	cee_item_if.sink    item,
	cee_result_if.source result,
	cee_cfg_if.sink     cfg
);

	localparam int RW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

	ctrl_cmd_t     cmd;
	dp_status_t    status;
	logic [RW-1:0] rd_row;

	assign cfg.ready = 1'b1;

	cee_ctrl #(
		.ENTRY_COUNT (ENTRY_COUNT),
		.RW          (RW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd),
		.rd_row     (rd_row)
	);

	cee_dp #(
		.ENTRY_COUNT (ENTRY_COUNT),
		.RW          (RW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_data (item.data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.rd_row    (rd_row),
		.status    (status),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_data  (result.data)
	);

endmodule
